[src/cbuf_pkg.sv]
// cbuf_pkg: shared constants, codes and types of the chunk buffer
// no dependencies; imported by every module of the block except cbuf_ram
`default_nettype none

package cbuf_pkg;

  // default geometry
  localparam int SLOTS_DEF = 16;
  localparam int PEERS_DEF = 8;

  // fixed field widths
  localparam int ID_W   = 31;
  localparam int TS_W   = 64;
  localparam int PEER_W = 3;
  localparam int CFG_W  = 5;
  // wide enough for any slot count or capacity up to 256
  localparam int CAP_W  = 9;
  // wide enough for a pending-ack count up to 64 peers
  localparam int CNT_W  = 7;

  // stream payload widths
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 16;

  // item kinds
  localparam logic [1:0] K_ADD    = 2'd0;
  localparam logic [1:0] K_EXPECT = 2'd1;
  localparam logic [1:0] K_ACK    = 2'd2;
  localparam logic [1:0] K_CLEAR  = 2'd3;

  // result status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_DUP     = 2'd1;
  localparam logic [1:0] STS_OLD     = 2'd2;
  localparam logic [1:0] STS_NOMATCH = 2'd3;

  // answer of the shared compare unit for one table entry
  typedef struct packed {
    logic             ident_eq;
    logic             better;
    logic [CNT_W-1:0] pop;
  } scan_res_t;

endpackage

`default_nettype wire

[src/cbuf_ram.sv]
// cbuf_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module cbuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/cbuf_scan_unit.sv]
// cbuf_scan_unit: shared compare unit applied to one table entry per cycle
// depends on cbuf_pkg
`default_nettype none

module cbuf_scan_unit #(
  parameter int PEERS = cbuf_pkg::PEERS_DEF
) (
  input  wire logic                      entry_valid,
  input  wire logic [cbuf_pkg::ID_W-1:0] entry_ident,
  input  wire logic [PEERS-1:0]          entry_wait,
  input  wire logic [cbuf_pkg::ID_W-1:0] key_ident,
  input  wire logic                      best_found,
  input  wire logic [cbuf_pkg::CNT_W-1:0] best_n,
  input  wire logic [cbuf_pkg::ID_W-1:0] best_ident,
  output cbuf_pkg::scan_res_t            res
);

  import cbuf_pkg::*;

  logic [CNT_W-1:0] pop;

  always_comb begin
    pop = '0;
    for (int i = 0; i < PEERS; i++) begin
      pop = pop + CNT_W'(entry_wait[i]);
    end
  end

  // victim order: most pending acks, ties to the smallest id
  always_comb begin
    res.pop      = pop;
    res.ident_eq = (entry_ident == key_ident);
    res.better   = entry_valid &&
                   (!best_found || (pop > best_n) ||
                    ((pop == best_n) && (entry_ident < best_ident)));
  end

endmodule

`default_nettype wire

[src/chunk_buffer_with_ack_eviction.sv]
// chunk_buffer_with_ack_eviction: top level, sequencer over the chunk table
// depends on cbuf_pkg, cbuf_ram, cbuf_scan_unit
`default_nettype none

// channel  dir  handshake         payload
// s_       in   tvalid/tready     tuser kind, tdata id/time/is_data/peer
// m_       out  tvalid/tready     tdata status/slot/evicted/cleared/stored_after
// cfg_     in   cfg_we            cfg_wdata slots_in_use
//
// add, expect and ack items run a scan: one table entry is read per cycle from
// the entry ram and passed through the shared compare unit, then a decide state
// and an output state follow; a clear item goes from accept straight to the
// output state
// reset is synchronous; it empties the table and leaves the ram contents as is
// the input side is ready only while the sequencer is idle; a result waiting on
// a stalled output does not block the next accept, only the next result

module chunk_buffer_with_ack_eviction #(
  parameter int SLOTS = cbuf_pkg::SLOTS_DEF,
  parameter int PEERS = cbuf_pkg::PEERS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // slave side
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // tdata fields from bit 0: ident[31], chunk_time[64], is_data[1], peer[3], zero fill
  input  wire logic [cbuf_pkg::IN_DATA_W-1:0] s_tdata,
  // tuser fields from bit 0: kind[2]
  input  wire logic [1:0]                     s_tuser,
  // master side
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // tdata fields from bit 0: status[2], slot[4], evicted[1], cleared[1],
  // stored_after[5], zero fill
  output logic [cbuf_pkg::OUT_DATA_W-1:0]     m_tdata,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [cbuf_pkg::CFG_W-1:0]     cfg_wdata
);

  import cbuf_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  // ram word: ident, stamp, data type, pending-ack bitmap
  localparam int EW = ID_W + TS_W + 1 + PEERS;

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state;

  // latched item
  logic [1:0]        kind_r;
  logic [ID_W-1:0]   id_r;
  logic [TS_W-1:0]   ts_r;
  logic              data_r;
  logic [PEER_W-1:0] peer_r;

  // config register and derived capacity
  logic [CFG_W-1:0] slots_in_use;
  logic [CAP_W-1:0] cap_lim;
  logic [CAP_W-1:0] cap;

  // table control state
  logic [SLOTS-1:0] valid;
  logic [CW-1:0]    count;
  logic [CAP_W-1:0] count_x;

  // scan pointer and read pipeline
  logic          issuing;
  logic [IW-1:0] idx;
  logic          pipe_v;
  logic [IW-1:0] pidx;
  logic [CAP_W-1:0] pidx_x;

  // scan results
  logic             dup;
  logic             hit;
  logic             free_found;
  logic [IW-1:0]    free_slot;
  logic             best_found;
  logic [IW-1:0]    best_idx;
  logic [CNT_W-1:0] best_n;
  logic [ID_W-1:0]  best_ident;
  logic [TS_W-1:0]  best_stamp;

  // result fields held for the output stage
  logic [1:0]    res_status;
  logic [IW-1:0] res_slot;
  logic          res_evicted;
  logic          res_cleared;

  // entry ram port signals
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_wdata;
  logic [EW-1:0]   ram_rdata;
  logic [ID_W-1:0] rd_ident;
  logic [TS_W-1:0] rd_stamp;
  logic            rd_data;
  logic [PEERS-1:0] rd_wait;
  logic [PEERS-1:0] peer_mask;
  logic             peer_ok;
  logic             match;

  scan_res_t su;

  // decide-stage outcome
  logic          d_place;
  logic          d_wipe;
  logic          d_evict;
  logic [IW-1:0] d_slot;
  logic [1:0]    d_status;

  logic [CAP_W-1:0] slot_x;
  logic [CAP_W-1:0] stored_x;

  // nothing is taken while reset is held
  assign s_tready = (state == S_IDLE) && !rst;

  // capacity: slots_in_use capped at SLOTS, zero counts as one
  always_comb begin
    cap_lim = (CAP_W'(slots_in_use) > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : CAP_W'(slots_in_use);
    cap     = (cap_lim == '0) ? CAP_W'(1) : cap_lim;
  end

  assign count_x = CAP_W'(count);
  assign pidx_x  = CAP_W'(pidx);

  // ram word decode
  assign rd_ident = ram_rdata[ID_W-1:0];
  assign rd_stamp = ram_rdata[ID_W +: TS_W];
  assign rd_data  = ram_rdata[ID_W+TS_W];
  assign rd_wait  = ram_rdata[ID_W+TS_W+1 +: PEERS];

  // a peer index beyond the bitmap never matches
  assign peer_ok   = (7'(peer_r) < 7'(PEERS));
  assign peer_mask = PEERS'(1) << peer_r;

  cbuf_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  cbuf_scan_unit #(
    .PEERS (PEERS)
  ) u_scan (
    .entry_valid (valid[pidx]),
    .entry_ident (rd_ident),
    .entry_wait  (rd_wait),
    .key_ident   (id_r),
    .best_found  (best_found),
    .best_n      (best_n),
    .best_ident  (best_ident),
    .res         (su)
  );

  // expect or ack hits a stored data chunk with the same id
  assign match = pipe_v && (state == S_SCAN) && (kind_r inside {K_EXPECT, K_ACK}) &&
                 valid[pidx] && rd_data && su.ident_eq && peer_ok;

  // add decision from the finished scan
  always_comb begin
    d_place  = 1'b0;
    d_wipe   = 1'b0;
    d_evict  = 1'b0;
    d_slot   = '0;
    d_status = STS_OK;
    if (dup) begin
      d_status = STS_DUP;
    end else if (count_x < cap) begin
      if (free_found) begin
        d_place = 1'b1;
        d_slot  = free_slot;
      end else begin
        d_status = STS_OLD;
      end
    end else if (!best_found) begin
      d_wipe  = 1'b1;
      d_place = 1'b1;
    end else if (best_ident < id_r) begin
      // victim is replaced in place
      d_place = 1'b1;
      d_evict = 1'b1;
      d_slot  = best_idx;
    end else if (best_stamp < ts_r) begin
      // whole table goes, new chunk lands in slot 0
      d_wipe  = 1'b1;
      d_place = 1'b1;
    end else begin
      d_status = STS_OLD;
    end
  end

  // ram write: pending-ack write-back for expect and ack during the scan, placement in the decide cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pidx;
    ram_wdata = {(kind_r == K_EXPECT) ? (rd_wait | peer_mask) : (rd_wait & ~peer_mask),
                 rd_data, rd_stamp, rd_ident};
    if (match) begin
      ram_we = 1'b1;
    end else if ((state == S_DECIDE) && (kind_r == K_ADD) && d_place) begin
      ram_we    = 1'b1;
      ram_waddr = d_slot;
      ram_wdata = {PEERS'(0), data_r, ts_r, id_r};
    end
  end

  assign slot_x   = CAP_W'(res_slot);
  assign stored_x = CAP_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid        <= '0;
      count        <= '0;
      slots_in_use <= CFG_W'(16);
      m_tvalid     <= 1'b0;
      issuing      <= 1'b0;
      pipe_v       <= 1'b0;
    end else begin
      if (cfg_we) begin
        slots_in_use <= cfg_wdata;
      end
      // a taken result leaves the output register unless a new one is loaded
      if (m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind_r      <= s_tuser;
            id_r        <= s_tdata[ID_W-1:0];
            ts_r        <= s_tdata[ID_W +: TS_W];
            data_r      <= s_tdata[ID_W+TS_W];
            peer_r      <= s_tdata[ID_W+TS_W+1 +: PEER_W];
            res_status  <= STS_OK;
            res_slot    <= '0;
            res_evicted <= 1'b0;
            res_cleared <= (s_tuser == K_CLEAR);
            dup         <= 1'b0;
            hit         <= 1'b0;
            free_found  <= 1'b0;
            best_found  <= 1'b0;
            idx         <= '0;
            if (s_tuser == K_CLEAR) begin
              valid <= '0;
              count <= '0;
              state <= S_DONE;
            end else begin
              issuing <= 1'b1;
              state   <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // issue side: one ram read per cycle
          pipe_v <= issuing;
          pidx   <= idx;
          if (issuing) begin
            if (idx == IW'(SLOTS - 1)) begin
              issuing <= 1'b0;
            end else begin
              idx <= idx + IW'(1);
            end
          end
          // compare side: entry read in the previous cycle
          if (pipe_v) begin
            if (kind_r == K_ADD) begin
              if (valid[pidx] && su.ident_eq) begin
                dup <= 1'b1;
              end
              if (!valid[pidx] && !free_found && (pidx_x < cap)) begin
                free_found <= 1'b1;
                free_slot  <= pidx;
              end
              if (su.better) begin
                best_found <= 1'b1;
                best_idx   <= pidx;
                best_n     <= su.pop;
                best_ident <= rd_ident;
                best_stamp <= rd_stamp;
              end
            end
            if (match) begin
              hit <= 1'b1;
            end
            // issuing is already low here, so the pipe empties by itself
            if (pidx == IW'(SLOTS - 1)) begin
              state <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          if (kind_r == K_ADD) begin
            res_status  <= d_status;
            res_slot    <= d_slot;
            res_evicted <= d_evict;
            res_cleared <= d_wipe;
            if (d_wipe) begin
              valid <= SLOTS'(1);
              count <= CW'(1);
            end else if (d_place) begin
              valid[d_slot] <= 1'b1;
              if (!d_evict) begin
                count <= count + CW'(1);
              end
            end
          end else begin
            res_status <= hit ? STS_OK : STS_NOMATCH;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          // output register free or emptied this cycle
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, stored_x[4:0], res_cleared, res_evicted,
                         slot_x[3:0], res_status};
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/cbuf_checker.sv]
// cbuf_checker: port-level assertions on the chunk buffer, bound to the top
// depends on cbuf_pkg and chunk_buffer_with_ack_eviction
`default_nettype none

module cbuf_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [cbuf_pkg::OUT_DATA_W-1:0] m_tdata
);

  import cbuf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one item at a time: the sequencer drops ready after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready stayed high after accept");

  // failed operations place nothing
  a_fail_no_place: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != STS_OK) |->
      (m_tdata[5:2] == 4'd0) && !m_tdata[6] && !m_tdata[7])
    else $error("failed operation reports a placement");

  // after a clear at most the new chunk is stored
  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7] |-> (m_tdata[12:8] <= 5'd1) && !m_tdata[6])
    else $error("clear left more than one entry");

  // no result is valid right after a reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind chunk_buffer_with_ack_eviction cbuf_checker u_cbuf_checker (.*);

`default_nettype wire
